>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; take it in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HPOC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define HPOC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/hpoc_pkg.sv
// Types, codes and helpers for the picture order count core.
// Depends on nothing; used by the divider, the core and the checker.
package hpoc_pkg;

   localparam int LEN_W = 9;

   localparam logic       REQ_PICTURE = 1'b0;
   localparam logic       REQ_TABLE   = 1'b1;
   localparam logic [1:0] MODE_LSB    = 2'd0;
   localparam logic [1:0] MODE_CYCLE  = 2'd1;

   localparam logic [2:0] REG_POC_MODE  = 3'd0;
   localparam logic [2:0] REG_LOG2_FNUM = 3'd1;
   localparam logic [2:0] REG_LOG2_LSB  = 3'd2;
   localparam logic [2:0] REG_CYC_LEN   = 3'd3;
   localparam logic [2:0] REG_NONREF    = 3'd4;
   localparam logic [2:0] REG_T2B       = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EVAL, ST_DIV, ST_SUM, ST_MUL, ST_CALC, ST_DONE
   } hpoc_state_type;

   typedef struct packed {
      logic               req_type;
      logic               idr_picture;
      logic [1:0]         ref_idc;
      logic [15:0]        frame_number;
      logic [15:0]        order_lsb;
      logic signed [31:0] bottom_delta;
      logic signed [31:0] cycle_delta_first;
      logic signed [31:0] cycle_delta_second;
      logic [7:0]         table_index;
      logic signed [31:0] table_value;
   } hpoc_req_type;

   typedef struct packed {
      logic signed [31:0] top_count;
      logic signed [31:0] bottom_count;
   } hpoc_rsp_type;

   typedef struct packed {
      logic             done;
      logic [31:0]      quot;
      logic [LEN_W-1:0] rem;
   } hpoc_div_res_type;

   // Saturate a log2 register to 4..16
   function automatic logic [4:0] clamp_log2(input logic [4:0] v);
      logic [4:0] r;
      if (v < 5'd4) r = 5'd4;
      else if (v > 5'd16) r = 5'd16;
      else r = v;
      return r;
   endfunction

   function automatic logic is_positive(input logic [31:0] v);
      return (v != 32'd0) && !v[31];
   endfunction

endpackage

>>> rtl/core/hpoc_ram.sv
// Generic single write port RAM with registered read.
// Depends on nothing.
module hpoc_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read, one address each
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/hpoc_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit by 9-bit.
// Depends on hpoc_pkg.
module hpoc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [31:0]                dividend,
   input  logic [hpoc_pkg::LEN_W-1:0] divisor,
   output hpoc_pkg::hpoc_div_res_type res
);
   import hpoc_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [5:0]       steps_ff, steps_in;
   logic [31:0]      quot_ff, quot_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [LEN_W-1:0] div_ff, div_in;
   logic [LEN_W:0]   trial;

   // Shift one bit in, subtract where it fits
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      steps_in = steps_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      trial    = {rem_ff, quot_ff[31]};
      if (start) begin
         busy_in  = 1'b1;
         steps_in = 6'd32;
         quot_in  = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in  = LEN_W'(trial - {1'b0, div_ff});
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = LEN_W'(trial);
            quot_in = {quot_ff[30:0], 1'b0};
         end
         steps_in = steps_ff - 6'd1;
         if (steps_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      steps_ff <= steps_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign res.done = done_ff;
   assign res.quot = quot_ff;
   assign res.rem  = rem_ff;
endmodule

>>> rtl/core/h264_picture_order_count_core.sv
// H.264 picture order count derivation, types 0, 1 and 2.
// Channels: req_ carries a picture or a cycle offset table write, rsp_
// carries top and bottom counts, csr_ is an APB-style register port.
// A transfer takes place when valid is high and stall is low.
// A table write gives no result; req_stall stays low after it.
// A picture raises req_stall until its result is loaded in the output
// register. Types 0 and 2, and type 1 without a positive frame count,
// go from ST_EVAL straight to ST_DONE and then load the output register.
// Type 1 with a positive frame count runs the bit-serial divider, then
// reads one table entry per cycle through the offset RAM port, then a
// multiply and a final add.
// The result holds in the output register while rsp_stall is high; a
// finished result waits there and the next one waits in its last state.
// Reset clears the registers to their defaults and the previous count
// state to zero; the offset table is undefined until written.
// Depends on hpoc_pkg, hpoc_ram and hpoc_div.
module h264_picture_order_count_core #(
   parameter int CYCLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hpoc_pkg::hpoc_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hpoc_pkg::hpoc_rsp_type rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [4:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import hpoc_pkg::*;

   localparam int AW = (CYCLE_DEPTH > 1) ? $clog2(CYCLE_DEPTH) : 1;
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(CYCLE_DEPTH);

   // Configuration registers
   logic [1:0]  mode_ff;
   logic [4:0]  l2fn_ff, l2lsb_ff;
   logic [7:0]  clen_ff;
   logic [31:0] nro_ff, t2b_ff;
   logic [2:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_LSB;
         l2fn_ff  <= 5'd4;
         l2lsb_ff <= 5'd4;
         clen_ff  <= '0;
         nro_ff   <= '0;
         t2b_ff   <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            REG_POC_MODE:  mode_ff  <= csr_pwdata[1:0];
            REG_LOG2_FNUM: l2fn_ff  <= csr_pwdata[4:0];
            REG_LOG2_LSB:  l2lsb_ff <= csr_pwdata[4:0];
            REG_CYC_LEN:   clen_ff  <= csr_pwdata[7:0];
            REG_NONREF:    nro_ff   <= csr_pwdata;
            REG_T2B:       t2b_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Register read-back
   always_comb begin
      unique case (reg_idx)
         REG_POC_MODE:  csr_prdata = {30'd0, mode_ff};
         REG_LOG2_FNUM: csr_prdata = {27'd0, l2fn_ff};
         REG_LOG2_LSB:  csr_prdata = {27'd0, l2lsb_ff};
         REG_CYC_LEN:   csr_prdata = {24'd0, clen_ff};
         REG_NONREF:    csr_prdata = nro_ff;
         REG_T2B:       csr_prdata = t2b_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // Control and working registers
   hpoc_state_type   state_ff, state_in;
   hpoc_req_type     req_ff, req_in;
   logic [31:0]      pmsb_ff, pmsb_in;
   logic [15:0]      plsb_ff, plsb_in;
   logic [15:0]      pfn_ff, pfn_in;
   logic [31:0]      poff_ff, poff_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [31:0]      cnt_ff, cnt_in;
   logic [LEN_W-1:0] issue_ff, issue_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [LEN_W-1:0] rd_pos_ff, rd_pos_in;
   logic [31:0]      sum_ff, sum_in;
   logic [31:0]      part_ff, part_in;
   logic [31:0]      prod_ff, prod_in;
   logic [31:0]      base_ff, base_in;
   logic [31:0]      badd_ff, badd_in;
   logic [31:0]      top_ff, top_in;
   logic [31:0]      bot_ff, bot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   hpoc_rsp_type     rsp_ff, rsp_in;

   logic             req_xfer, tbl_wr;
   logic [31:0]      ram_rdata;
   logic             div_start;
   logic [31:0]      div_num;
   hpoc_div_res_type div_res;

   // Derived picture quantities
   logic [LEN_W-1:0] len;
   logic [16:0]      max_fn, max_lsb, half;
   logic [15:0]      fnum, lsb, plsb_eff, ldiff_dn, ldiff_up;
   logic [31:0]      pmsb_eff, msb, off, absn, nref_add, poc, ptop;
   logic             is_ref, idr;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign tbl_wr    = req_xfer && (req_data.req_type == REQ_TABLE)
                      && ({1'b0, req_data.table_index} < DEPTH_LEN);

   hpoc_ram #(.WIDTH(32), .DEPTH(CYCLE_DEPTH), .ADDR_W(AW)) u_ram (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (AW'(req_data.table_index)),
      .wr_data (req_data.table_value),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   hpoc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (len),
      .res      (div_res)
   );

   // Work out counts for the held picture
   always_comb begin
      len      = ({1'b0, clen_ff} > DEPTH_LEN) ? DEPTH_LEN : {1'b0, clen_ff};
      is_ref   = (req_ff.ref_idc != 2'd0);
      idr      = req_ff.idr_picture;
      max_fn   = 17'd1 << clamp_log2(l2fn_ff);
      fnum     = req_ff.frame_number & max_fn[15:0] - 16'd1;
      max_lsb  = 17'd1 << clamp_log2(l2lsb_ff);
      half     = max_lsb >> 1;
      lsb      = req_ff.order_lsb & 16'(max_lsb - 17'd1);
      pmsb_eff = idr ? 32'd0 : pmsb_ff;
      plsb_eff = idr ? 16'd0 : plsb_ff;
      ldiff_dn = plsb_eff - lsb;
      ldiff_up = lsb - plsb_eff;
      if (lsb < plsb_eff && {1'b0, ldiff_dn} >= half) begin
         msb = pmsb_eff + 32'(max_lsb);
      end else if (lsb > plsb_eff && {1'b0, ldiff_up} > half) begin
         msb = pmsb_eff - 32'(max_lsb);
      end else begin
         msb = pmsb_eff;
      end
      if (idr) off = 32'd0;
      else if (pfn_ff > fnum) off = poff_ff + 32'(max_fn);
      else off = poff_ff;
      absn = (len != '0) ? off + 32'(fnum) : 32'd0;
      if (!is_ref && is_positive(absn)) absn = absn - 32'd1;
      nref_add = is_ref ? 32'd0 : nro_ff;
      if (idr) poc = 32'd0;
      else if (!is_ref) poc = {off[30:0] + 31'(fnum), 1'b0} - 32'd1;
      else poc = {off[30:0] + 31'(fnum), 1'b0};
      ptop = msb + 32'(lsb);
   end

   assign div_num = absn - 32'd1;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      pmsb_in      = pmsb_ff;
      plsb_in      = plsb_ff;
      pfn_in       = pfn_ff;
      poff_in      = poff_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      rd_pos_in    = issue_ff;
      sum_in       = sum_ff;
      part_in      = part_ff;
      prod_in      = prod_ff;
      base_in      = base_ff;
      badd_in      = badd_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_data.req_type == REQ_PICTURE) begin
               req_in   = req_data;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (mode_ff == MODE_LSB) begin
               top_in   = ptop;
               bot_in   = ptop + req_ff.bottom_delta;
               state_in = ST_DONE;
               if (is_ref) begin
                  pmsb_in = msb;
                  plsb_in = lsb;
               end
            end else begin
               pfn_in  = fnum;
               poff_in = off;
               if (mode_ff == MODE_CYCLE) begin
                  if (is_positive(absn) && len != '0) begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end else begin
                     top_in   = nref_add + req_ff.cycle_delta_first;
                     bot_in   = top_in + t2b_ff + req_ff.cycle_delta_second;
                     state_in = ST_DONE;
                  end
               end else begin
                  top_in   = poc;
                  bot_in   = poc;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               cnt_in   = div_res.quot;
               pos_in   = div_res.rem;
               issue_in = '0;
               sum_in   = '0;
               part_in  = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // Issue one table read a cycle, accumulate its data in the cycle after
            if (issue_ff < len) begin
               rd_vld_in = 1'b1;
               issue_in  = issue_ff + LEN_W'(1);
            end
            if (rd_vld_ff) begin
               sum_in = sum_ff + ram_rdata;
               if (rd_pos_ff <= pos_ff) part_in = part_ff + ram_rdata;
            end
            if (issue_ff == len && !rd_vld_ff) state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = cnt_ff * sum_ff;
            base_in  = part_ff + nref_add + req_ff.cycle_delta_first;
            badd_in  = t2b_ff + req_ff.cycle_delta_second;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            top_in   = prod_ff + base_ff;
            bot_in   = top_in + badd_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.top_count     = top_ff;
               rsp_in.bottom_count  = bot_ff;
               state_in             = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         pmsb_ff      <= '0;
         plsb_ff      <= '0;
         pfn_ff       <= '0;
         poff_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         pmsb_ff      <= pmsb_in;
         plsb_ff      <= plsb_in;
         pfn_ff       <= pfn_in;
         poff_ff      <= poff_in;
      end
      req_ff    <= req_in;
      pos_ff    <= pos_in;
      cnt_ff    <= cnt_in;
      issue_ff  <= issue_in;
      rd_pos_ff <= rd_pos_in;
      sum_ff    <= sum_in;
      part_ff   <= part_in;
      prod_ff   <= prod_in;
      base_ff   <= base_in;
      badd_ff   <= badd_in;
      top_ff    <= top_in;
      bot_ff    <= bot_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

>>> rtl/core/hpoc_checker.sv
// Port-level checks for the picture order count core, bound to the top.
// Depends on hpoc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hpoc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input hpoc_pkg::hpoc_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_stall
);
   import hpoc_pkg::*;

   // A picture transfer makes the block busy
   `HPOC_ASSERT_NEXT(a_pic_busy, clock, reset, req_valid && !req_stall && req_data.req_type == REQ_PICTURE, req_stall)
   // A table write leaves the block free
   `HPOC_ASSERT_NEXT(a_tbl_free, clock, reset, req_valid && !req_stall && req_data.req_type == REQ_TABLE, !req_stall)
   // A new result only follows busy work
   `HPOC_ASSERT_NOW(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_stall))
   // A stalled result is not dropped
   `HPOC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
endmodule

bind h264_picture_order_count_core hpoc_checker u_hpoc_checker (.*);
